@@ design/erbd_pkg.sv @@
`default_nettype none

package erbd_pkg;

    // Width of the running total inside the block and its port width.
    localparam int TOTAL_BITS_DEFAULT = 24;
    localparam int TOTAL_OUT_BITS     = 24;

    // Entries in the token queue between the parser and the accumulator.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] EXT_FLAG_MASK   = 8'h80;
    localparam logic [6:0] EXT_HIGH_MASK   = 7'h7F;
    localparam logic [7:0] MARKER_DESC_MAX = 8'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BYTE  = 3'd1,
        PH_DESC  = 3'd2,
        PH_EXT   = 3'd3,
        PH_VALUE = 3'd4
    } phase_t;

    // One decoded run, passed from the parser to the accumulator.
    // first restarts the running total before this run is added.
    typedef struct packed {
        logic [7:0]  value;
        logic [15:0] length;
        logic        eob;
        logic        trunc;
        logic        first;
    } token_t;

endpackage

`default_nettype wire

@@ design/erbd_front.sv @@
`default_nettype none

module erbd_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      data_byte,
    input  wire logic            block_start,
    input  wire logic            block_end,
    output logic                 tok_valid,
    output erbd_pkg::token_t     tok
);

    erbd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       marker_reg, marker_next;
    logic [14:0]      count_reg, count_next;
    logic             first_reg, first_next;
    logic             open_token;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= erbd_pkg::PH_IDLE;
            marker_reg <= 8'd0;
            count_reg  <= 15'd0;
            first_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            marker_reg <= marker_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        marker_next = marker_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        tok_valid   = 1'b0;
        tok         = '0;
        open_token  = 1'b0;

        if (accept)
        begin
            if (block_start)
            begin
                marker_next = data_byte;
                count_next  = 15'd0;
                phase_next  = erbd_pkg::PH_BYTE;
                first_next  = 1'b1;
                if (block_end)
                begin
                    tok_valid  = 1'b1;
                    tok.eob    = 1'b1;
                    tok.first  = 1'b1;
                    first_next = 1'b0;
                    phase_next = erbd_pkg::PH_IDLE;
                end
            end
            else
            begin
                unique case (phase_reg)
                    erbd_pkg::PH_IDLE:
                    begin
                        phase_next = erbd_pkg::PH_IDLE;
                    end
                    erbd_pkg::PH_BYTE:
                    begin
                        if (data_byte != marker_reg)
                        begin
                            tok_valid  = 1'b1;
                            tok.value  = data_byte;
                            tok.length = 16'd1;
                        end
                        else
                        begin
                            phase_next = erbd_pkg::PH_DESC;
                            open_token = 1'b1;
                        end
                    end
                    erbd_pkg::PH_DESC:
                    begin
                        if (data_byte <= erbd_pkg::MARKER_DESC_MAX)
                        begin
                            tok_valid  = 1'b1;
                            tok.value  = marker_reg;
                            tok.length = {8'd0, data_byte} + 16'd1;
                            phase_next = erbd_pkg::PH_BYTE;
                        end
                        else if ((data_byte & erbd_pkg::EXT_FLAG_MASK) != 8'd0)
                        begin
                            count_next = {8'd0, data_byte[6:0] & erbd_pkg::EXT_HIGH_MASK};
                            phase_next = erbd_pkg::PH_EXT;
                            open_token = 1'b1;
                        end
                        else
                        begin
                            count_next = {7'd0, data_byte};
                            phase_next = erbd_pkg::PH_VALUE;
                            open_token = 1'b1;
                        end
                    end
                    erbd_pkg::PH_EXT:
                    begin
                        count_next = {count_reg[6:0], data_byte};
                        phase_next = erbd_pkg::PH_VALUE;
                        open_token = 1'b1;
                    end
                    erbd_pkg::PH_VALUE:
                    begin
                        tok_valid  = 1'b1;
                        tok.value  = data_byte;
                        tok.length = {1'b0, count_reg} + 16'd1;
                        phase_next = erbd_pkg::PH_BYTE;
                    end
                    default:
                    begin
                        phase_next = erbd_pkg::PH_IDLE;
                    end
                endcase

                // A block that ends while a token is still open is cut short.
                if (block_end && open_token)
                begin
                    tok_valid = 1'b1;
                    tok.trunc = 1'b1;
                end

                if (tok_valid)
                begin
                    tok.eob    = block_end;
                    tok.first  = first_reg;
                    first_next = 1'b0;
                    if (block_end)
                    begin
                        phase_next = erbd_pkg::PH_IDLE;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/erbd_queue.sv @@
`default_nettype none

module erbd_queue
#(
    parameter int DEPTH = erbd_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire erbd_pkg::token_t push_tok,
    input  wire logic             pop,
    output logic                  not_full,
    output logic                  not_empty,
    output erbd_pkg::token_t      head_tok
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    erbd_pkg::token_t  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_tok  = entry_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

`default_nettype wire

@@ design/erbd_back.sv @@
`default_nettype none

module erbd_back
#(
    parameter int TOTAL_BITS = erbd_pkg::TOTAL_BITS_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             tok_valid,
    input  wire erbd_pkg::token_t tok,
    output logic                  tok_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            run_value,
    output logic [15:0]           run_length,
    output logic                  end_of_block,
    output logic [erbd_pkg::TOTAL_OUT_BITS-1:0] total_length,
    output logic                  truncated
);

    localparam int OUT_W = erbd_pkg::TOTAL_OUT_BITS;
    localparam int WIDE_W = (TOTAL_BITS > OUT_W) ? TOTAL_BITS : OUT_W;

    logic                  valid_reg, valid_next;
    logic [7:0]            value_reg;
    logic [15:0]           length_reg;
    logic                  eob_reg;
    logic                  trunc_reg;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [TOTAL_BITS-1:0] base;
    logic [TOTAL_BITS:0]   sum;
    logic [WIDE_W-1:0]     total_wide;
    logic                  load;

    assign load    = tok_valid && (!valid_reg || out_ready);
    assign tok_pop = load;

    // The running total saturates; the carry out of the add flags overflow.
    always_comb
    begin
        base       = tok.first ? '0 : total_reg;
        sum        = {1'b0, base} + (TOTAL_BITS + 1)'(tok.length);
        total_next = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
        valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg  <= tok.value;
            length_reg <= tok.length;
            eob_reg    <= tok.eob;
            trunc_reg  <= tok.trunc;
        end
    end

    assign total_wide   = WIDE_W'(total_reg);
    assign total_length = (total_wide > WIDE_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                                : total_wide[OUT_W-1:0];
    assign out_valid    = valid_reg;
    assign run_value    = value_reg;
    assign run_length   = length_reg;
    assign end_of_block = eob_reg;
    assign truncated    = trunc_reg;

endmodule

`default_nettype wire

@@ design/escape_rle_byte_decoder.sv @@
// Escape-marker run-length decoder that turns a compressed byte stream into
// run tokens (value, length) plus a saturating running total per block.
// Input channel: in_valid/in_ready carry data_byte, block_start, block_end.
// The byte flagged by block_start is the block's escape marker.
// Output channel: out_valid/out_ready carry run_value, run_length,
// end_of_block, total_length and truncated, at most one token per byte.
// Throughput is one byte per cycle while the token queue has room; the parser
// decides each byte as it is accepted, and the accumulator adds one run per
// cycle unless the output is stalled. The edge that accepts a byte writes its
// token into the token queue; the output register then loads the token from
// the queue head once the output is not stalled.
// When the receiver stalls, tokens collect in the queue and in_ready drops
// only once the queue is full; the parser and accumulator stall separately.
// Reset empties the queue and the output register and returns the parser to
// waiting for a block start; bytes without block_start are then ignored.
`default_nettype none

module escape_rle_byte_decoder
#(
    parameter int TOTAL_BITS  = erbd_pkg::TOTAL_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = erbd_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        block_start,
    input  wire logic        block_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       run_value,
    output logic [15:0]      run_length,
    output logic             end_of_block,
    output logic [erbd_pkg::TOTAL_OUT_BITS-1:0] total_length,
    output logic             truncated
);

    logic             accept;
    logic             front_valid;
    erbd_pkg::token_t front_tok;
    logic             q_not_full;
    logic             q_not_empty;
    erbd_pkg::token_t q_tok;
    logic             q_pop;

    assign in_ready = q_not_full;
    assign accept   = in_valid && q_not_full;

    erbd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .block_start (block_start),
        .block_end   (block_end),
        .tok_valid   (front_valid),
        .tok         (front_tok)
    );

    erbd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_tok  (front_tok),
        .pop       (q_pop),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .head_tok  (q_tok)
    );

    erbd_back #(.TOTAL_BITS(TOTAL_BITS)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (q_not_empty),
        .tok          (q_tok),
        .tok_pop      (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .run_value    (run_value),
        .run_length   (run_length),
        .end_of_block (end_of_block),
        .total_length (total_length),
        .truncated    (truncated)
    );

    // A truncated token carries no run and always closes its block.
    a_trunc_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && truncated) |-> (run_length == 16'd0 && end_of_block && run_value == 8'd0))
        else $error("truncated token with a run or without end of block");

    // An empty run only ever ends a block.
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_length == 16'd0) |-> end_of_block)
        else $error("empty run that does not end a block");

    // An empty run that is not a truncation is a marker-only block.
    a_marker_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && run_length == 16'd0 && !truncated) |-> (total_length == '0))
        else $error("marker-only block with nonzero total");

    // A run never exceeds the longest extended count.
    a_run_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (run_length <= 16'd32768))
        else $error("run length out of range");

endmodule

`default_nettype wire

@@ tb/escape_rle_run_checker.sv @@
`timescale 1ns / 100ps

module escape_rle_run_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        block_start,
    input  logic        block_end,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  run_value,
    input  logic [15:0] run_length,
    input  logic        end_of_block,
    input  logic [erbd_pkg::TOTAL_OUT_BITS-1:0] total_length,
    input  logic        truncated,
    output int          mismatch_count,
    output int          runs_outstanding
);

    localparam int TOT_W = erbd_pkg::TOTAL_BITS_DEFAULT;
    localparam int OUT_W = erbd_pkg::TOTAL_OUT_BITS;
    localparam logic [TOT_W-1:0] TOTAL_CEILING = '1;
    localparam logic [63:0] SHOWN_CEILING = (64'd1 << OUT_W) - 64'd1;

    typedef struct packed {
        logic [7:0]       value;
        logic [15:0]      length;
        logic             eob;
        logic [OUT_W-1:0] total;
        logic             trunc;
    } run_token_t;

    erbd_pkg::phase_t parse_phase;
    logic [7:0]       block_marker;
    logic [14:0]      run_count;
    logic [TOT_W-1:0] block_total;
    run_token_t       expected_runs[$];
    run_token_t       want;
    int               runs_seen;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] expected_value);
        if (got !== expected_value)
            report_mismatch($sformatf("run %0d: %s is %h, expected %h",
                                      runs_seen, name, got, expected_value));
    endtask

    // Adds a run to the block total and queues the token the block must show.
    task automatic queue_run(input logic [7:0] value, input logic [15:0] len,
                             input logic eob, input logic trunc);
        logic [TOT_W:0] sum;
        logic [63:0]    shown;
        run_token_t     tok;
        sum = {1'b0, block_total} + len;
        block_total = sum[TOT_W] ? TOTAL_CEILING : sum[TOT_W-1:0];
        shown = 64'(block_total);
        if (shown > SHOWN_CEILING)
            shown = SHOWN_CEILING;
        tok.value  = value;
        tok.length = len;
        tok.eob    = eob;
        tok.total  = shown[OUT_W-1:0];
        tok.trunc  = trunc;
        expected_runs.push_back(tok);
        if (eob)
            parse_phase = erbd_pkg::PH_IDLE;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic first,
                               input logic last);
        if (first)
        begin
            block_marker = b;
            run_count    = '0;
            block_total  = '0;
            parse_phase  = erbd_pkg::PH_BYTE;
            if (last)
                queue_run(8'd0, 16'd0, 1'b1, 1'b0);
        end
        else
        begin
            case (parse_phase)
                erbd_pkg::PH_BYTE:
                begin
                    if (b != block_marker)
                        queue_run(b, 16'd1, last, 1'b0);
                    else
                    begin
                        parse_phase = erbd_pkg::PH_DESC;
                        if (last)
                            queue_run(8'd0, 16'd0, 1'b1, 1'b1);
                    end
                end
                erbd_pkg::PH_DESC:
                begin
                    if (b <= erbd_pkg::MARKER_DESC_MAX)
                    begin
                        parse_phase = erbd_pkg::PH_BYTE;
                        queue_run(block_marker, {8'd0, b} + 16'd1, last, 1'b0);
                    end
                    else
                    begin
                        if ((b & erbd_pkg::EXT_FLAG_MASK) != 8'd0)
                        begin
                            run_count   = {8'd0, b[6:0] & erbd_pkg::EXT_HIGH_MASK};
                            parse_phase = erbd_pkg::PH_EXT;
                        end
                        else
                        begin
                            run_count   = {7'd0, b};
                            parse_phase = erbd_pkg::PH_VALUE;
                        end
                        if (last)
                            queue_run(8'd0, 16'd0, 1'b1, 1'b1);
                    end
                end
                erbd_pkg::PH_EXT:
                begin
                    run_count   = {run_count[6:0], b};
                    parse_phase = erbd_pkg::PH_VALUE;
                    if (last)
                        queue_run(8'd0, 16'd0, 1'b1, 1'b1);
                end
                erbd_pkg::PH_VALUE:
                begin
                    parse_phase = erbd_pkg::PH_BYTE;
                    queue_run(b, {1'b0, run_count} + 16'd1, last, 1'b0);
                end
                default:
                    parse_phase = erbd_pkg::PH_IDLE;
            endcase
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            parse_phase    = erbd_pkg::PH_IDLE;
            block_marker   = '0;
            run_count      = '0;
            block_total    = '0;
            runs_seen      = 0;
            mismatch_count = 0;
            expected_runs.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                decode_byte(data_byte, block_start, block_end);
            if (out_valid && out_ready)
            begin
                if (expected_runs.size() == 0)
                    report_mismatch($sformatf("unexpected run: value %h length %0d",
                                              run_value, run_length));
                else
                begin
                    want = expected_runs.pop_front();
                    check_field("run_value", 32'(run_value), 32'(want.value));
                    check_field("run_length", 32'(run_length), 32'(want.length));
                    check_field("end_of_block", 32'(end_of_block), 32'(want.eob));
                    check_field("total_length", 32'(total_length), 32'(want.total));
                    check_field("truncated", 32'(truncated), 32'(want.trunc));
                end
                runs_seen++;
            end
        end
        runs_outstanding = expected_runs.size();
    end

endmodule

@@ tb/escape_rle_byte_decoder_tb.sv @@
`timescale 1ns / 100ps

module escape_rle_byte_decoder_tb;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SATURATE_RUNS  = 515;

    typedef enum int {
        TK_LITERAL,
        TK_MARKER_RUN,
        TK_SHORT_RUN,
        TK_LONG_RUN
    } token_kind_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        block_start;
    logic        block_end;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  run_value;
    logic [15:0] run_length;
    logic        end_of_block;
    logic [erbd_pkg::TOTAL_OUT_BITS-1:0] total_length;
    logic        truncated;

    int   mismatch_count;
    int   runs_outstanding;
    int   cycle_count;
    int   bytes_sent;
    logic steady;
    logic rx_hold;

    escape_rle_byte_decoder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .block_start  (block_start),
        .block_end    (block_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .run_value    (run_value),
        .run_length   (run_length),
        .end_of_block (end_of_block),
        .total_length (total_length),
        .truncated    (truncated)
    );

    escape_rle_run_checker run_checker
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .block_start      (block_start),
        .block_end        (block_end),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .run_value        (run_value),
        .run_length       (run_length),
        .end_of_block     (end_of_block),
        .total_length     (total_length),
        .truncated        (truncated),
        .mismatch_count   (mismatch_count),
        .runs_outstanding (runs_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("escape_rle_byte_decoder_tb: FAIL");
        $finish;
    end

    // Receiver side. A hold request stalls the output for a fixed stretch.
    initial
    begin
        int hold_cnt;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                out_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < RX_HOLD_CYCLES; hold_cnt++)
                    @(negedge clk);
                rx_hold = 1'b0;
            end
            out_ready <= rst_n && (steady || ($urandom_range(99) >= 28));
        end
    end

    // Called at a falling edge; returns at the falling edge after the
    // transaction, leaving in_valid high for the caller to reuse or lower.
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        while (!steady && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        block_start <= first;
        block_end   <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // A cut between 1 and the token size sends only that many bytes.
    task automatic send_token(input logic [7:0] marker, input token_kind_t kind,
                              input int cut, input logic last);
        logic [7:0] tok[4];
        int         n;
        int         i;
        tok[0] = marker;
        tok[1] = 8'($urandom);
        tok[2] = 8'($urandom);
        tok[3] = 8'($urandom);
        case (kind)
            TK_LITERAL:
            begin
                do
                    tok[0] = 8'($urandom);
                while (tok[0] == marker);
                n = 1;
            end
            TK_MARKER_RUN:
            begin
                tok[1] = 8'($urandom_range(erbd_pkg::MARKER_DESC_MAX));
                n = 2;
            end
            TK_SHORT_RUN:
            begin
                tok[1] = 8'($urandom_range(erbd_pkg::EXT_HIGH_MASK, 3));
                n = 3;
            end
            default:
            begin
                tok[1] = erbd_pkg::EXT_FLAG_MASK | 8'($urandom_range(127));
                n = 4;
            end
        endcase
        if (cut > 0 && cut < n)
            n = cut;
        for (i = 0; i < n; i++)
            send_byte(tok[i], 1'b0, last && (i == n - 1));
    endtask

    function automatic token_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return TK_LITERAL;
        else if (r < 55)
            return TK_MARKER_RUN;
        else if (r < 75)
            return TK_SHORT_RUN;
        return TK_LONG_RUN;
    endfunction

    // Mostly well-formed blocks; some are cut short, abandoned, empty, or
    // preceded by stray bytes outside any block.
    task automatic send_random_block();
        int          shape;
        int          n_tok;
        int          t;
        logic [7:0]  marker;
        logic        last;
        token_kind_t kind;
        shape  = $urandom_range(99);
        marker = 8'($urandom);
        n_tok  = $urandom_range(12, 1);
        if (shape < 5)
            repeat ($urandom_range(2, 1))
                send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
        if (shape >= 5 && shape < 9)
        begin
            send_byte(marker, 1'b1, 1'b1);
        end
        else
        begin
            send_byte(marker, 1'b1, 1'b0);
            for (t = 0; t < n_tok; t++)
            begin
                last = (t == n_tok - 1);
                kind = pick_kind();
                if (last && shape >= 9 && shape < 17)
                    send_token(marker, kind, $urandom_range(3, 1), 1'b1);
                else if (last && shape >= 17 && shape < 23)
                    send_token(marker, kind, $urandom_range(3, 1), 1'b0);
                else
                    send_token(marker, kind, 0, last);
            end
        end
    endtask

    task automatic drain_runs();
        in_valid <= 1'b0;
        while (rx_hold || runs_outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] marker;
        int         i;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = 8'd0;
        block_start = 1'b0;
        block_end   = 1'b0;
        steady      = 1'b0;
        rx_hold     = 1'b0;
        bytes_sent  = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: stray byte while idle, then a marker-only block.
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        // Marker zero: literal, both marker-run extremes, short runs at both
        // descriptor ends, and long runs with the smallest and largest count.
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(erbd_pkg::MARKER_DESC_MAX, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(erbd_pkg::EXT_FLAG_MASK, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h5A, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b1);
        // Block ends right on a marker byte.
        send_byte(8'h7E, 1'b1, 1'b0);
        send_byte(8'h7E, 1'b0, 1'b1);
        // A new block start abandons an open token.
        send_byte(8'h10, 1'b1, 1'b0);
        send_byte(8'h10, 1'b0, 1'b0);
        send_byte(8'h20, 1'b1, 1'b0);
        send_byte(8'h21, 1'b0, 1'b1);

        while (bytes_sent < 150)
            send_random_block();

        // Stall the output long enough to back up the token queue.
        rx_hold = 1'b1;
        marker  = 8'($urandom);
        send_byte(marker, 1'b1, 1'b0);
        for (i = 0; i < 40; i++)
            send_token(marker, TK_LITERAL, 0, i == 39);
        drain_runs();

        steady = 1'b1;
        while (bytes_sent < 260)
            send_random_block();
        steady = 1'b0;

        // Enough maximum-length runs to push the block total into saturation.
        marker = 8'($urandom);
        send_byte(marker, 1'b1, 1'b0);
        for (i = 0; i < SATURATE_RUNS; i++)
        begin
            send_byte(marker, 1'b0, 1'b0);
            send_byte(8'hFF, 1'b0, 1'b0);
            send_byte(8'hFF, 1'b0, 1'b0);
            send_byte(8'($urandom), 1'b0, 1'b0);
        end
        send_token(marker, TK_LITERAL, 0, 1'b0);
        send_token(marker, TK_MARKER_RUN, 0, 1'b1);

        drain_runs();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && runs_outstanding == 0)
            $display("escape_rle_byte_decoder_tb: PASS");
        else
            $display("escape_rle_byte_decoder_tb: FAIL");
        $finish;
    end

endmodule
